### hdl/ebpf_pkg.sv
// Shared types, codes and helpers of the eBPF execute core.
package ebpf_pkg;

  localparam int PROGRAM_DEPTH_DEF = 4096;
  localparam int REG_COUNT_DEF     = 11;
  localparam int LEN_W             = 13;
  localparam int PC_W              = 16;
  localparam int IDX_W             = 4;

  localparam logic [1:0] OPER_START  = 2'd0;
  localparam logic [1:0] OPER_EXEC   = 2'd1;
  localparam logic [1:0] OPER_RETURN = 2'd2;
  localparam logic [1:0] OPER_IDLE   = 2'd3;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_EXIT  = 3'd1;
  localparam logic [2:0] ST_DIVZ  = 3'd2;
  localparam logic [2:0] ST_BADCL = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  localparam logic [2:0] CLS_LD    = 3'd0;
  localparam logic [2:0] CLS_LDX   = 3'd1;
  localparam logic [2:0] CLS_ST    = 3'd2;
  localparam logic [2:0] CLS_STX   = 3'd3;
  localparam logic [2:0] CLS_ALU   = 3'd4;
  localparam logic [2:0] CLS_JMP   = 3'd5;
  localparam logic [2:0] CLS_JMP32 = 3'd6;
  localparam logic [2:0] CLS_ALU64 = 3'd7;

  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_MUL  = 4'h2;
  localparam logic [3:0] OP_DIV  = 4'h3;
  localparam logic [3:0] OP_OR   = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LSH  = 4'h6;
  localparam logic [3:0] OP_RSH  = 4'h7;
  localparam logic [3:0] OP_NEG  = 4'h8;
  localparam logic [3:0] OP_MOD  = 4'h9;
  localparam logic [3:0] OP_XOR  = 4'ha;
  localparam logic [3:0] OP_MOV  = 4'hb;
  localparam logic [3:0] OP_ARSH = 4'hc;

  localparam logic [3:0] JOP_JA   = 4'h0;
  localparam logic [3:0] JOP_JEQ  = 4'h1;
  localparam logic [3:0] JOP_JGT  = 4'h2;
  localparam logic [3:0] JOP_JGE  = 4'h3;
  localparam logic [3:0] JOP_JSET = 4'h4;
  localparam logic [3:0] JOP_JNE  = 4'h5;
  localparam logic [3:0] JOP_JSGT = 4'h6;
  localparam logic [3:0] JOP_JSGE = 4'h7;
  localparam logic [3:0] JOP_CALL = 4'h8;
  localparam logic [3:0] JOP_EXIT = 4'h9;
  localparam logic [3:0] JOP_JLT  = 4'ha;
  localparam logic [3:0] JOP_JLE  = 4'hb;
  localparam logic [3:0] JOP_JSLT = 4'hc;
  localparam logic [3:0] JOP_JSLE = 4'hd;

  localparam logic [1:0] SZ_DW = 2'd3;

  typedef struct packed {
    logic [1:0]  oper;
    logic [7:0]  opcode;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [15:0] offset;
    logic [31:0] imm;
    logic [63:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_pc;
    logic        mem_request;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [63:0] mem_address;
    logic [63:0] mem_write_data;
    logic [63:0] return_value;
  } result_t;

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    case (sz)
      2'd0:    size_mask = 64'h0000_0000_ffff_ffff;
      2'd1:    size_mask = 64'h0000_0000_0000_ffff;
      2'd2:    size_mask = 64'h0000_0000_0000_00ff;
      default: size_mask = '1;
    endcase
  endfunction

endpackage

### hdl/ebpf_front.sv
// Input side: accept words into a short queue for the execute unit.
module ebpf_front
  import ebpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_take,
  output item_t q_item
);

  localparam int DEPTH = 2;

  item_t      slots [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_take);
    end
  end

endmodule

### hdl/ebpf_divider.sv
// Radix-2 restoring divider giving quotient and remainder.
module ebpf_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);

  logic        busy;
  logic [6:0]  steps;
  logic [63:0] dvs;
  logic [64:0] trial;

  assign trial = {remainder, quotient[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= 7'd0;
    end else begin
      done <= !start && busy && (steps == 7'd63);
      if (start) begin
        busy      <= 1'b1;
        steps     <= 7'd0;
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        if (trial[64]) begin
          remainder <= {remainder[62:0], quotient[63]};
          quotient  <= {quotient[62:0], 1'b0};
        end else begin
          remainder <= trial[63:0];
          quotient  <= {quotient[62:0], 1'b1};
        end
        steps <= steps + 7'd1;
        if (steps == 7'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### hdl/ebpf_back.sv
// Execute unit: register file, program counter, ALU, memory and jump handling.
module ebpf_back
  import ebpf_pkg::*;
#(
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
  parameter int REG_COUNT     = REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LEN_W-1:0]  program_length,
  input  logic [63:0]       stack_top_address,
  input  logic              q_valid,
  output logic              q_take,
  input  item_t             q_item,
  output logic              out_valid,
  input  logic              out_stall,
  output result_t           out_res
);

  localparam logic [16:0] DEPTH_C = 17'(PROGRAM_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE} state_t;

  state_t      state;
  item_t       it;
  result_t     res_q;
  logic [63:0] regs [REG_COUNT];
  logic [15:0] pc;
  logic        wide_pending;
  logic [31:0] wide_low;
  logic [3:0]  wide_dest;
  logic        load_pending;
  logic [3:0]  load_dest;
  logic [1:0]  load_size;

  logic [63:0] opa, opb, mul_p;
  logic [1:0]  mul_step;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_pp;
  logic [63:0] rs, rdv, imm64, off64;
  logic [16:0] eff_len;
  logic        div_start, div_done;
  logic [63:0] div_q, div_r, div_a, div_b;
  logic [2:0]  cls;
  logic [3:0]  op;
  logic        xsrc, is64;
  logic [63:0] alu_r;
  logic        taken;
  logic [63:0] sa, sb;
  logic [5:0]  shamt;
  logic [31:0] a32, sar32_r;

  function automatic logic [63:0] rread(input logic [3:0] i, input logic [63:0] r [REG_COUNT]);
    rread = (32'(i) < REG_COUNT) ? r[i] : 64'd0;
  endfunction

  assign eff_len  = ({4'd0, program_length} < DEPTH_C) ? {4'd0, program_length} : DEPTH_C;
  assign cls      = it.opcode[2:0];
  assign op       = it.opcode[7:4];
  assign xsrc     = it.opcode[3];
  assign is64     = (cls == CLS_ALU64);
  assign rdv      = rread(it.dst, regs);
  assign rs       = rread(it.src, regs);
  assign imm64    = {{32{it.imm[31]}}, it.imm};
  assign off64    = {{48{it.offset[15]}}, it.offset};
  assign opa      = is64 ? rdv : {32'd0, rdv[31:0]};
  assign opb      = xsrc ? (is64 ? rs : {32'd0, rs[31:0]}) : (is64 ? imm64 : {32'd0, it.imm});
  assign div_a    = opa;
  assign div_b    = opb;
  assign q_take   = (state == S_IDLE) && q_valid;
  assign shamt    = is64 ? opb[5:0] : {1'b0, opb[4:0]};
  assign a32      = opa[31:0];
  assign sar32_r  = $unsigned($signed(a32) >>> shamt[4:0]);
  assign sa       = rdv ^ 64'h8000_0000_0000_0000;
  assign sb       = (xsrc ? rs : imm64) ^ 64'h8000_0000_0000_0000;
  assign mul_x    = (mul_step == 2'd2) ? opa[63:32] : opa[31:0];
  assign mul_y    = (mul_step == 2'd1) ? opb[63:32] : opb[31:0];
  assign mul_pp   = mul_x * mul_y;

  ebpf_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    case (op)
      OP_ADD:  alu_r = opa + opb;
      OP_SUB:  alu_r = opa - opb;
      OP_OR:   alu_r = opa | opb;
      OP_AND:  alu_r = opa & opb;
      OP_LSH:  alu_r = opa << shamt;
      OP_RSH:  alu_r = opa >> shamt;
      OP_NEG:  alu_r = 64'd0 - opa;
      OP_XOR:  alu_r = opa ^ opb;
      OP_MOV:  alu_r = opb;
      OP_ARSH: alu_r = is64 ? $unsigned($signed(opa) >>> shamt) : {32'd0, sar32_r};
      default: alu_r = opa;
    endcase
    if (!is64) alu_r = {32'd0, alu_r[31:0]};
  end

  always_comb begin
    logic [63:0] a, b;
    a = rdv;
    b = xsrc ? rs : imm64;
    case (op)
      JOP_JA:   taken = 1'b1;
      JOP_JEQ:  taken = (a == b);
      JOP_JNE:  taken = (a != b);
      JOP_JGT:  taken = (a > b);
      JOP_JGE:  taken = (a >= b);
      JOP_JSET: taken = ((a & b) != 64'd0);
      JOP_JSGT: taken = (sb < sa);
      JOP_JSGE: taken = !(sa < sb);
      JOP_JLT:  taken = (a < b);
      JOP_JLE:  taken = (a <= b);
      JOP_JSLT: taken = (sa < sb);
      JOP_JSLE: taken = !(sb < sa);
      default:  taken = 1'b0;
    endcase
  end

  assign div_start = (state == S_EXEC) && (cls == CLS_ALU64 || cls == CLS_ALU) &&
                     (op == OP_DIV || op == OP_MOD) && (opb != 64'd0) &&
                     !wide_pending && !load_pending && ({1'b0, pc} < eff_len) &&
                     (it.oper == OPER_EXEC);

  function automatic result_t rep(input logic [15:0] p, input logic lp,
                                  input logic [16:0] len, input logic [63:0] r0);
    result_t r;
    r = '0;
    r.next_pc = p;
    if (lp) r.status = ST_LOAD;
    else if ({1'b0, p} >= len) begin
      r.status = ST_EXIT;
      r.return_value = r0;
    end else r.status = ST_RUN;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    result_t     res;
    logic [15:0] npc;
    logic [63:0] wv;
    logic        wen;
    logic [3:0]  wi;
    state_t      state_next;
    res = '0;
    npc = pc + 16'd1;
    wv  = '0;
    wen = 1'b0;
    wi  = it.dst;
    state_next = S_DONE;
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      pc           <= '0;
      wide_pending <= 1'b0;
      wide_low     <= '0;
      wide_dest    <= '0;
      load_pending <= 1'b0;
      load_dest    <= '0;
      load_size    <= '0;
      mul_step     <= 2'd0;
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            it    <= q_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (it.oper == OPER_START) begin
            for (int i = 0; i < REG_COUNT; i++) begin
              regs[i] <= (i == 1) ? it.data : ((i == 10) ? stack_top_address : 64'd0);
            end
            pc            <= '0;
            wide_pending  <= 1'b0;
            load_pending  <= 1'b0;
            res_q         <= rep(16'd0, 1'b0, eff_len, 64'd0);
          end else if (it.oper == OPER_RETURN) begin
            if (load_pending) begin
              if (32'(load_dest) < REG_COUNT) begin
                regs[load_dest] <= it.data & size_mask(load_size);
              end
              load_pending <= 1'b0;
              res_q <= rep(pc, 1'b0, eff_len,
                           (load_dest == 4'd0) ? (it.data & size_mask(load_size)) : regs[0]);
            end else begin
              res_q <= rep(pc, 1'b0, eff_len, regs[0]);
            end
          end else if (it.oper == OPER_IDLE || load_pending || {1'b0, pc} >= eff_len) begin
            res_q <= rep(pc, load_pending, eff_len, regs[0]);
          end else if (wide_pending) begin
            wv = {it.imm, wide_low};
            wi = wide_dest;
            wen = 1'b1;
            wide_pending <= 1'b0;
            pc <= npc;
            res = rep(npc, 1'b0, eff_len, regs[0]);
            if (wi == 4'd0) res.return_value = ({1'b0, npc} >= eff_len) ? wv : 64'd0;
            res_q <= res;
          end else begin
            case (cls)
              CLS_ALU64, CLS_ALU: begin
                if ((op == OP_DIV || op == OP_MOD) && opb == 64'd0) begin
                  res = '0;
                  res.status = ST_DIVZ;
                  res.next_pc = pc;
                  res_q <= res;
                end else if (op == OP_DIV || op == OP_MOD) begin
                  state_next = S_DIV;
                end else if (op == OP_MUL) begin
                  mul_p <= mul_pp;
                  mul_step <= 2'd1;
                  state_next = S_MUL;
                end else begin
                  wv  = alu_r;
                  wen = is64 || (op <= OP_ARSH);
                end
              end
              CLS_LDX: begin
                res.mem_request = 1'b1;
                res.mem_size = it.opcode[4:3];
                res.mem_address = rs + off64;
                load_pending <= 1'b1;
                load_dest <= it.dst;
                load_size <= it.opcode[4:3];
              end
              CLS_ST, CLS_STX: begin
                res.mem_request = 1'b1;
                res.mem_write = 1'b1;
                res.mem_size = it.opcode[4:3];
                res.mem_address = rdv + off64;
                res.mem_write_data = ((cls == CLS_ST) ? imm64 : rs) & size_mask(it.opcode[4:3]);
              end
              CLS_JMP: begin
                if (op == JOP_CALL) begin
                  wv = '0;
                  wi = 4'd0;
                  wen = 1'b1;
                end
                if (taken) npc = pc + it.offset + 16'd1;
              end
              CLS_LD: begin
                if (it.opcode[4:3] == SZ_DW) begin
                  if ({1'b0, pc} + 17'd1 < eff_len) begin
                    wide_pending <= 1'b1;
                    wide_low <= it.imm;
                    wide_dest <= it.dst;
                  end else begin
                    wv = {32'd0, it.imm};
                    wen = 1'b1;
                  end
                end
              end
              default: begin
                res = '0;
                res.status = ST_BADCL;
                res.next_pc = pc;
                res_q <= res;
              end
            endcase
            if (cls == CLS_JMP && op == JOP_EXIT) begin
              res = '0;
              res.status = ST_EXIT;
              res.next_pc = pc;
              res.return_value = regs[0];
              res_q <= res;
            end else if (cls == CLS_JMP32) begin
            end else if ((cls == CLS_ALU64 || cls == CLS_ALU) &&
                         (op == OP_DIV || op == OP_MOD || op == OP_MUL)) begin
            end else begin
              result_t rr;
              rr = rep(npc, (cls == CLS_LDX), eff_len,
                       (wen && wi == 4'd0) ? wv : regs[0]);
              rr.mem_request    = res.mem_request;
              rr.mem_write      = res.mem_write;
              rr.mem_size       = res.mem_size;
              rr.mem_address    = res.mem_address;
              rr.mem_write_data = res.mem_write_data;
              res_q <= rr;
              pc <= npc;
            end
          end
          if (wen && 32'(wi) < REG_COUNT) regs[wi] <= wv;
          state <= state_next;
        end
        S_MUL: begin
          if (mul_step == 2'd1) begin
            mul_p <= mul_p + {mul_pp[31:0], 32'd0};
            mul_step <= 2'd2;
          end else begin
            wv = mul_p + {mul_pp[31:0], 32'd0};
            if (!is64) wv = {32'd0, wv[31:0]};
            if (32'(it.dst) < REG_COUNT) regs[it.dst] <= wv;
            pc <= npc;
            res_q <= rep(npc, 1'b0, eff_len, (it.dst == 4'd0) ? wv : regs[0]);
            mul_step <= 2'd0;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            wv = (op == OP_DIV) ? div_q : div_r;
            if (!is64) wv = {32'd0, wv[31:0]};
            if (32'(it.dst) < REG_COUNT) regs[it.dst] <= wv;
            pc <= npc;
            res_q <= rep(npc, 1'b0, eff_len, (it.dst == 4'd0) ? wv : regs[0]);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_res <= res_q;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == S_DONE)) out_valid <= 1'b0;
    end
  end

endmodule

### hdl/ebpf_instruction_execute_core.sv
// Top level of the eBPF execute core.
// The execute unit takes one word at a time: it takes a new word only after its last result is in the output register.
// A two-entry queue takes new words while the execute unit works.
// Synchronous active-high rst clears registers, program counter and pending flags.
module ebpf_instruction_execute_core
  import ebpf_pkg::*;
#(
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
  parameter int REG_COUNT     = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  opcode,
  input  logic [3:0]  dest_index,
  input  logic [3:0]  source_index,
  input  logic signed [15:0] offset,
  input  logic signed [31:0] immediate,
  input  logic [63:0] data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] next_pc,
  output logic        mem_request,
  output logic        mem_write,
  output logic [1:0]  mem_size,
  output logic [63:0] mem_address,
  output logic [63:0] mem_write_data,
  output logic [63:0] return_value
);

  logic [LEN_W-1:0] program_length;
  logic [63:0]      stack_top_address;
  item_t            in_item, q_item;
  logic             q_valid, q_take;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length    <= '0;
      stack_top_address <= '0;
    end else if (cfg_write) begin
      if (cfg_index == 1'b0) program_length <= cfg_data[LEN_W-1:0];
      else stack_top_address <= cfg_data;
    end
  end

  assign in_item = '{oper: operation, opcode: opcode, dst: dest_index, src: source_index,
                     offset: offset, imm: immediate, data: data_word};

  ebpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item)
  );

  ebpf_back #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .REG_COUNT     (REG_COUNT)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .program_length    (program_length),
    .stack_top_address (stack_top_address),
    .q_valid           (q_valid),
    .q_take            (q_take),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_res           (res)
  );

  assign status         = res.status;
  assign next_pc        = res.next_pc;
  assign mem_request    = res.mem_request;
  assign mem_write      = res.mem_write;
  assign mem_size       = res.mem_size;
  assign mem_address    = res.mem_address;
  assign mem_write_data = res.mem_write_data;
  assign return_value   = res.return_value;

endmodule

### hdl/ebpf_checker.sv
// Port-level checks of the eBPF execute core, bound to the top level.
module ebpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic        mem_request,
  input logic        mem_write,
  input logic [63:0] mem_write_data,
  input logic [63:0] return_value
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= 3'd4))
    else $error("bad status code");

  a_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_request && !mem_write |-> status == 3'd4 && mem_write_data == 64'd0)
    else $error("load without awaiting status");

  a_ret: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 3'd1 |-> return_value == 64'd0)
    else $error("return value outside exit");

endmodule

bind ebpf_instruction_execute_core ebpf_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .mem_request    (mem_request),
  .mem_write      (mem_write),
  .mem_write_data (mem_write_data),
  .return_value   (return_value)
);

### sim/tb.sv
// Testbench for the eBPF execute core: directed and random programs checked against a local predictor.
`timescale 1ns / 1ps
module tb;
  import ebpf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OPER_IDLE;
  logic [7:0]  opcode = '0;
  logic [3:0]  dest_index = '0;
  logic [3:0]  source_index = '0;
  logic signed [15:0] offset = '0;
  logic signed [31:0] immediate = '0;
  logic [63:0] data_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] next_pc;
  logic        mem_request;
  logic        mem_write;
  logic [1:0]  mem_size;
  logic [63:0] mem_address;
  logic [63:0] mem_write_data;
  logic [63:0] return_value;

  ebpf_instruction_execute_core i_dut (.*);

  always #5 clk = ~clk;

  // engine shadow state
  logic [63:0] regs [11];
  logic [15:0] pc_q;
  logic        wide_pend, load_pend;
  logic [31:0] wide_low;
  logic [3:0]  wide_dst, load_dst;
  logic [1:0]  load_sz;
  logic [12:0] prog_len;
  logic [63:0] stack_top;

  item_t   word_queue[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      cycle = 0;
  bit      calm = 1'b0;

  function automatic logic [63:0] rdreg(logic [3:0] i);
    return i < 11 ? regs[i] : 64'd0;
  endfunction

  function automatic void wrreg(logic [3:0] i, logic [63:0] v);
    if (i < 11) regs[i] = v;
  endfunction

  function automatic logic [63:0] sz_mask(logic [1:0] sz);
    case (sz)
      2'd0: return 64'hffff_ffff;
      2'd1: return 64'hffff;
      2'd2: return 64'hff;
      default: return '1;
    endcase
  endfunction

  function automatic logic [12:0] eff_len();
    return prog_len < 4096 ? prog_len : 13'd4096;
  endfunction

  function automatic void fill_status(ref result_t r);
    r.next_pc = pc_q;
    if (load_pend) r.status = ST_LOAD;
    else if ({1'b0, pc_q} >= {4'd0, eff_len()}) begin
      r.status = ST_EXIT;
      r.return_value = regs[0];
    end else r.status = ST_RUN;
  endfunction

  function automatic result_t predict_step(item_t it);
    result_t r;
    logic [2:0]  cls;
    logic [3:0]  op;
    logic [1:0]  sz;
    logic [63:0] off, imm, a, b, res;
    logic [31:0] a32, b32, r32;
    logic [15:0] nxt;
    bit taken, touch;
    r = '0;
    cls = it.opcode[2:0];
    op = it.opcode[7:4];
    sz = it.opcode[4:3];
    off = {{48{it.offset[15]}}, it.offset};
    imm = {{32{it.imm[31]}}, it.imm};
    nxt = pc_q + 16'd1;
    if (it.oper == OPER_START) begin
      foreach (regs[i]) regs[i] = '0;
      regs[1] = it.data;
      regs[10] = stack_top;
      pc_q = '0;
      wide_pend = 1'b0;
      load_pend = 1'b0;
      fill_status(r);
      return r;
    end
    if (it.oper == OPER_RETURN) begin
      if (load_pend) begin
        wrreg(load_dst, it.data & sz_mask(load_sz));
        load_pend = 1'b0;
      end
      fill_status(r);
      return r;
    end
    if (it.oper == OPER_IDLE || load_pend || {1'b0, pc_q} >= {4'd0, eff_len()}) begin
      fill_status(r);
      return r;
    end
    if (wide_pend) begin
      wrreg(wide_dst, {it.imm, wide_low});
      wide_pend = 1'b0;
      pc_q = nxt;
      fill_status(r);
      return r;
    end
    case (cls)
      CLS_ALU64: begin
        a = rdreg(it.dst);
        b = it.opcode[3] ? rdreg(it.src) : imm;
        res = a;
        case (op)
          OP_ADD: res = a + b;
          OP_SUB: res = a - b;
          OP_MUL: res = a * b;
          OP_DIV, OP_MOD: begin
            if (b == 0) begin
              r.status = ST_DIVZ;
              r.next_pc = pc_q;
              return r;
            end
            res = op == OP_DIV ? a / b : a % b;
          end
          OP_OR: res = a | b;
          OP_AND: res = a & b;
          OP_LSH: res = a << b[5:0];
          OP_RSH: res = a >> b[5:0];
          OP_NEG: res = -a;
          OP_XOR: res = a ^ b;
          OP_MOV: res = b;
          OP_ARSH: res = $signed(a) >>> b[5:0];
          default: ;
        endcase
        wrreg(it.dst, res);
      end
      CLS_ALU: begin
        a32 = 32'(rdreg(it.dst));
        b32 = it.opcode[3] ? 32'(rdreg(it.src)) : it.imm;
        r32 = a32;
        touch = 1'b1;
        case (op)
          OP_ADD: r32 = a32 + b32;
          OP_SUB: r32 = a32 - b32;
          OP_MUL: r32 = a32 * b32;
          OP_DIV, OP_MOD: begin
            if (b32 == 0) begin
              r.status = ST_DIVZ;
              r.next_pc = pc_q;
              return r;
            end
            r32 = op == OP_DIV ? a32 / b32 : a32 % b32;
          end
          OP_OR: r32 = a32 | b32;
          OP_AND: r32 = a32 & b32;
          OP_LSH: r32 = a32 << b32[4:0];
          OP_RSH: r32 = a32 >> b32[4:0];
          OP_NEG: r32 = -a32;
          OP_XOR: r32 = a32 ^ b32;
          OP_MOV: r32 = b32;
          OP_ARSH: r32 = $signed(a32) >>> b32[4:0];
          default: touch = 1'b0;
        endcase
        if (touch) wrreg(it.dst, {32'd0, r32});
      end
      CLS_LDX: begin
        r.mem_request = 1'b1;
        r.mem_size = sz;
        r.mem_address = rdreg(it.src) + off;
        load_pend = 1'b1;
        load_dst = it.dst;
        load_sz = sz;
      end
      CLS_ST, CLS_STX: begin
        r.mem_request = 1'b1;
        r.mem_write = 1'b1;
        r.mem_size = sz;
        r.mem_address = rdreg(it.dst) + off;
        r.mem_write_data = (cls == CLS_ST ? imm : rdreg(it.src)) & sz_mask(sz);
      end
      CLS_JMP: begin
        a = rdreg(it.dst);
        b = it.opcode[3] ? rdreg(it.src) : imm;
        taken = 1'b0;
        case (op)
          JOP_EXIT: begin
            r.status = ST_EXIT;
            r.next_pc = pc_q;
            r.return_value = regs[0];
            return r;
          end
          JOP_JA: taken = 1'b1;
          JOP_CALL: regs[0] = '0;
          JOP_JEQ: taken = a == b;
          JOP_JNE: taken = a != b;
          JOP_JGT: taken = a > b;
          JOP_JGE: taken = a >= b;
          JOP_JSET: taken = (a & b) != 0;
          JOP_JSGT: taken = $signed(a) > $signed(b);
          JOP_JSGE: taken = $signed(a) >= $signed(b);
          JOP_JLT: taken = a < b;
          JOP_JLE: taken = a <= b;
          JOP_JSLT: taken = $signed(a) < $signed(b);
          JOP_JSLE: taken = $signed(a) <= $signed(b);
          default: ;
        endcase
        if (taken) nxt = pc_q + off[15:0] + 16'd1;
      end
      CLS_LD: begin
        if (sz == SZ_DW) begin
          if ({1'b0, pc_q} + 17'd1 < {4'd0, eff_len()}) begin
            wide_pend = 1'b1;
            wide_low = it.imm;
            wide_dst = it.dst;
          end else wrreg(it.dst, {32'd0, it.imm});
        end
      end
      default: begin
        r.status = ST_BADCL;
        r.next_pc = pc_q;
        return r;
      end
    endcase
    pc_q = nxt;
    fill_status(r);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic item_t rand_exec();
    item_t it;
    logic [3:0] op;
    logic [2:0] cls;
    it = '0;
    it.oper = OPER_EXEC;
    cls = $urandom_range(0, 99) < 3 ? CLS_JMP32 : 3'($urandom_range(0, 7));
    if (cls == CLS_JMP32) cls = $urandom_range(0, 9) == 0 ? CLS_JMP32 : CLS_ALU64;
    op = 4'($urandom_range(0, 15));
    if (cls == CLS_JMP && op == JOP_EXIT && $urandom_range(0, 3) != 0) op = JOP_JEQ;
    it.opcode = {op, 1'($urandom()), cls};
    if (cls == CLS_LD && $urandom_range(0, 3) != 0) it.opcode[4:3] = SZ_DW;
    it.dst = $urandom_range(0, 20) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    it.src = $urandom_range(0, 20) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    it.offset = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($signed($urandom_range(0, 6)) - 3);
    case ($urandom_range(0, 4))
      0: it.imm = 32'($urandom_range(0, 70));
      1: it.imm = 32'h8000_0000;
      2: it.imm = 32'h7fff_ffff;
      default: it.imm = $urandom();
    endcase
    it.data = rand64();
    return it;
  endfunction

  task automatic put_exec(logic [7:0] code, int d, int s, int off, int imm);
    item_t it;
    it = '0;
    it.oper = OPER_EXEC;
    it.opcode = code;
    it.dst = 4'(d);
    it.src = 4'(s);
    it.offset = 16'(off);
    it.imm = 32'(imm);
    word_queue.push_back(it);
  endtask

  task automatic put_simple(logic [1:0] oper, logic [63:0] data);
    item_t it;
    it = '0;
    it.oper = oper;
    it.data = data;
    it.opcode = 8'($urandom());
    it.dst = 4'($urandom());
    it.src = 4'($urandom());
    it.offset = 16'($urandom());
    it.imm = $urandom();
    word_queue.push_back(it);
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == 0) prog_len = val[12:0];
    else stack_top = val;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((word_queue.size() != 0 || in_valid || expected_results.size() != 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_step(word_queue.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (word_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          in_valid <= 1'b1;
          operation <= word_queue[0].oper;
          opcode <= word_queue[0].opcode;
          dest_index <= word_queue[0].dst;
          source_index <= word_queue[0].src;
          offset <= word_queue[0].offset;
          immediate <= word_queue[0].imm;
          data_word <= word_queue[0].data;
        end else in_valid <= 1'b0;
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 22);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", {61'd0, status}, '0);
      end else begin
        w = expected_results.pop_front();
        if (status != w.status) report_mismatch("status", 64'(status), 64'(w.status));
        if (next_pc != w.next_pc) report_mismatch("next_pc", 64'(next_pc), 64'(w.next_pc));
        if (mem_request != w.mem_request)
          report_mismatch("mem_request", 64'(mem_request), 64'(w.mem_request));
        if (mem_write != w.mem_write)
          report_mismatch("mem_write", 64'(mem_write), 64'(w.mem_write));
        if (mem_size != w.mem_size) report_mismatch("mem_size", 64'(mem_size), 64'(w.mem_size));
        if (mem_address != w.mem_address)
          report_mismatch("mem_address", mem_address, w.mem_address);
        if (mem_write_data != w.mem_write_data)
          report_mismatch("mem_write_data", mem_write_data, w.mem_write_data);
        if (return_value != w.return_value)
          report_mismatch("return_value", return_value, w.return_value);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > 2000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    foreach (regs[i]) regs[i] = '0;
    pc_q = '0;
    wide_pend = 1'b0;
    load_pend = 1'b0;
    wide_low = '0;
    wide_dst = '0;
    load_dst = '0;
    load_sz = '0;
    prog_len = '0;
    stack_top = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty program: everything reports exited
    put_simple(OPER_START, 64'h1234);
    put_exec({OP_ADD, 1'b0, CLS_ALU64}, 0, 0, 0, 5);
    drain();

    write_reg(0, 64'd4096);
    write_reg(1, '1);
    put_simple(OPER_START, '1);
    put_exec({OP_MOV, 1'b0, CLS_ALU64}, 2, 0, 0, 32'h8000_0000);
    put_exec({OP_DIV, 1'b0, CLS_ALU64}, 2, 0, 0, 0);
    put_exec({OP_MOD, 1'b1, CLS_ALU}, 2, 3, 0, 0);
    put_exec({OP_ARSH, 1'b0, CLS_ALU64}, 2, 0, 0, 32'd99);
    put_exec({OP_LSH, 1'b0, CLS_ALU}, 1, 0, 0, 32'd45);
    put_exec({OP_ADD, 1'b0, CLS_ALU64}, 13, 0, 0, 7);
    put_exec({4'he, 1'b1, CLS_ALU}, 1, 2, 0, 0);
    put_exec({4'h0, 1'b0, CLS_JMP32}, 0, 0, 0, 0);
    put_exec({3'b000, 2'b11, CLS_LD}, 4, 0, 0, 32'hffff_ffff);
    put_exec('0, 0, 0, 16'hffff, 32'h8000_0001);
    put_exec({3'b011, 2'b10, CLS_LDX}, 5, 10, 16'h8000, 0);
    put_exec({OP_ADD, 1'b0, CLS_ALU64}, 0, 0, 0, 1);
    put_simple(OPER_RETURN, '1);
    put_simple(OPER_RETURN, '1);
    put_simple(OPER_IDLE, 64'd0);
    put_exec({3'b011, 2'b11, CLS_STX}, 10, 1, 16'h7fff, 0);
    put_exec({3'b000, 2'b01, CLS_ST}, 1, 0, 16'h8000, 32'hffff_ffff);
    put_exec({JOP_CALL, 1'b0, CLS_JMP}, 0, 0, 0, 0);
    put_exec({JOP_JSGT, 1'b1, CLS_JMP}, 1, 4, 16'h7fff, 0);
    put_exec({JOP_JA, 1'b0, CLS_JMP}, 0, 0, 16'h8000, 0);
    put_exec({JOP_EXIT, 1'b0, CLS_JMP}, 0, 0, 0, 0);
    drain();

    // short program: wide immediate in the last slot, run off the end
    write_reg(0, 64'd3);
    write_reg(1, 64'h0);
    put_simple(OPER_START, 64'd0);
    put_exec({JOP_JA, 1'b0, CLS_JMP}, 0, 0, 1, 0);
    put_exec({3'b000, 2'b11, CLS_LD}, 0, 0, 0, 32'h8765_4321);
    put_exec({3'b000, 2'b11, CLS_LD}, 0, 0, 0, 32'h1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_reg(0, 64'd4096);
        1: write_reg(0, 64'h1fff);
        2: write_reg(0, 64'd40);
        default: write_reg(0, 64'd1);
      endcase
      write_reg(1, rand64());
      calm = (phase == 1);
      for (int n = 0; n < 325; n++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (load_pend_hint(n) || pick < 3) put_simple(OPER_START, rand64());
        else if (pick < 12) put_simple(OPER_RETURN, rand64());
        else if (pick < 14) put_simple(OPER_IDLE, rand64());
        else word_queue.push_back(rand_exec());
      end
      drain();
    end
    calm = 0;
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  function automatic bit load_pend_hint(int n);
    return n == 0;
  endfunction

endmodule
